### rtl/core/cu_pkg.sv
// Shared types and constants for the combination unranking block.
// Used by every module under rtl/core; depends on nothing.
package cu_pkg;

  localparam int N_MAX_DEF = 64;
  localparam int K_MAX_DEF = 16;

  localparam int RANK_W = 64;
  localparam int SET_W = 7;
  localparam int CHOOSE_W = 5;
  localparam int POS_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHOOSE_COUNT = 1'd1;

  localparam logic [SET_W-1:0] SET_SIZE_RST = 7'd49;
  localparam logic [CHOOSE_W-1:0] CHOOSE_COUNT_RST = 5'd6;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              err;
  } job_t;

  typedef struct packed {
    logic [SET_W-1:0] element_value;
    logic [POS_W-1:0] position;
    logic             last;
    logic             error;
  } res_t;

endpackage

### rtl/core/combination_unrank.sv
// Top level of the lexicographic combination unranking block.
// Depends on cu_pkg, cu_front, cu_binom_mem and cu_back.
//
// Usage: the input side is a queue. Write a 1-based rank with in_push while
// in_full is low; rank zero is treated as rank one. The result side is a
// queue too: while out_empty is low the oldest result is on the out_ ports
// and out_pop takes it. Each rank yields choose_count results in ascending
// order with out_last on the final one, or a single result with out_error
// set when the rank exceeds C(n,k) or the settings are invalid.
// Configuration is written through cfg_write_en, cfg_index and cfg_data
// while the block is idle; index 0 is set_size, index 1 is choose_count.
// After reset the binomial table is filled from Pascal's triangle; ranks
// are queued but not processed during that time. A rank then takes one
// binomial table read and compare per candidate value. When the receiver
// stalls, the two-entry result queue fills and the walk pauses; the
// two-entry input queue keeps accepting until it is full.
module combination_unrank #(
  parameter int N_MAX = cu_pkg::N_MAX_DEF,
  parameter int K_MAX = cu_pkg::K_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [cu_pkg::RANK_W-1:0]     in_rank,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [cu_pkg::SET_W-1:0]      out_element_value,
  output logic [cu_pkg::POS_W-1:0]      out_position,
  output logic                          out_last,
  output logic                          out_error,
  input  logic                          cfg_write_en,
  input  logic [cu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cu_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(N_MAX + 1);
  localparam int BW = $clog2(K_MAX + 1);

  logic [cu_pkg::SET_W-1:0]    set_size_r;
  logic [cu_pkg::CHOOSE_W-1:0] choose_count_r;
  logic                        job_valid, job_pop;
  cu_pkg::job_t                job;
  logic                        mem_ready, rd_en;
  logic [AW-1:0]               rd_a;
  logic [BW-1:0]               rd_b;
  logic [cu_pkg::RANK_W-1:0]   rd_data;
  cu_pkg::res_t                res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r <= cu_pkg::SET_SIZE_RST;
      choose_count_r <= cu_pkg::CHOOSE_COUNT_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        cu_pkg::CFG_SET_SIZE: set_size_r <= cfg_data;
        cu_pkg::CFG_CHOOSE_COUNT: choose_count_r <= cfg_data[cu_pkg::CHOOSE_W-1:0];
        default: ;
      endcase
    end
  end

  cu_front #(.N_MAX(N_MAX), .K_MAX(K_MAX)) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_rank(in_rank), .set_size(set_size_r), .choose_count(choose_count_r),
    .job_valid(job_valid), .job(job), .job_pop(job_pop)
  );

  cu_binom_mem #(.N_MAX(N_MAX), .K_MAX(K_MAX)) u_mem (
    .clk(clk), .rst_n(rst_n), .rd_en(rd_en), .rd_a(rd_a), .rd_b(rd_b),
    .rd_data(rd_data), .ready(mem_ready)
  );

  cu_back #(.N_MAX(N_MAX), .K_MAX(K_MAX)) u_back (
    .clk(clk), .rst_n(rst_n), .set_size(set_size_r),
    .choose_count(choose_count_r), .job_valid(job_valid), .job(job),
    .job_pop(job_pop), .mem_ready(mem_ready), .rd_en(rd_en), .rd_a(rd_a),
    .rd_b(rd_b), .rd_data(rd_data), .out_empty(out_empty),
    .out_pop(out_pop), .out_res(res)
  );

  assign out_element_value = res.element_value;
  assign out_position = res.position;
  assign out_last = res.last;
  assign out_error = res.error;

endmodule

### rtl/core/cu_front.sv
// Front end: accepts ranks, flags invalid settings and queues the jobs.
// Depends on cu_pkg.
module cu_front #(
  parameter int N_MAX = cu_pkg::N_MAX_DEF,
  parameter int K_MAX = cu_pkg::K_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [cu_pkg::RANK_W-1:0]   in_rank,
  input  logic [cu_pkg::SET_W-1:0]    set_size,
  input  logic [cu_pkg::CHOOSE_W-1:0] choose_count,
  output logic                        job_valid,
  output cu_pkg::job_t                job,
  input  logic                        job_pop
);

  cu_pkg::job_t q_r [2];
  logic         head_r, head_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         acc;
  logic         tail;
  cu_pkg::job_t nj;

  assign in_full = (cnt_r == 2'd2);
  assign acc = in_push && !in_full;
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[head_r];
  assign tail = head_r ^ cnt_r[0];

  always_comb begin
    nj.rank = (in_rank == '0) ? cu_pkg::RANK_W'(1) : in_rank;
    nj.err = (choose_count == '0) || (32'(choose_count) > K_MAX) ||
             (32'(set_size) > N_MAX) || ({2'b00, choose_count} > set_size);
    head_nxt = head_r ^ (job_pop && job_valid);
    cnt_nxt = cnt_r + {1'b0, acc} - {1'b0, job_pop && job_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      head_r <= head_nxt;
      cnt_r <= cnt_nxt;
    end
    if (acc) begin
      q_r[tail] <= nj;
    end
  end

endmodule

### rtl/core/cu_binom_mem.sv
// Binomial coefficient memory, filled with Pascal's triangle after reset.
// Depends on cu_pkg.
module cu_binom_mem #(
  parameter int N_MAX = cu_pkg::N_MAX_DEF,
  parameter int K_MAX = cu_pkg::K_MAX_DEF,
  localparam int AW = $clog2(N_MAX + 1),
  localparam int BW = $clog2(K_MAX + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_a,
  input  logic [BW-1:0]             rd_b,
  output logic [cu_pkg::RANK_W-1:0] rd_data,
  output logic                      ready
);

  localparam int DEPTH = (N_MAX + 1) * (K_MAX + 1);
  localparam int DW = $clog2(DEPTH);

  logic [cu_pkg::RANK_W-1:0] mem [DEPTH];
  logic [cu_pkg::RANK_W-1:0] row_r [K_MAX + 1];
  logic [cu_pkg::RANK_W-1:0] nv;
  logic [cu_pkg::RANK_W-1:0] rd_data_r;
  logic [AW-1:0]             a_r;
  logic [BW-1:0]             b_r;
  logic                      ready_r;
  logic [DW-1:0]             wr_addr, rd_addr;

  assign ready = ready_r;
  assign rd_data = rd_data_r;
  assign wr_addr = DW'(32'(a_r) * (K_MAX + 1) + 32'(b_r));
  assign rd_addr = DW'(32'(rd_a) * (K_MAX + 1) + 32'(rd_b));

  always_comb begin
    if (b_r == '0) begin
      nv = cu_pkg::RANK_W'(1);
    end else if (a_r == '0) begin
      nv = '0;
    end else begin
      nv = row_r[K_MAX] + row_r[(K_MAX > 0) ? K_MAX - 1 : 0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= BW'(K_MAX);
      ready_r <= 1'b0;
    end else if (!ready_r) begin
      if (b_r == '0) begin
        b_r <= BW'(K_MAX);
        if (32'(a_r) == N_MAX) begin
          ready_r <= 1'b1;
        end else begin
          a_r <= a_r + AW'(1);
        end
      end else begin
        b_r <= b_r - BW'(1);
      end
    end
    if (!ready_r) begin
      mem[wr_addr] <= nv;
      row_r[0] <= nv;
      for (int i = 1; i <= K_MAX; i++) begin
        row_r[i] <= row_r[i-1];
      end
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/cu_back.sv
// Back end: walks candidate values per position and queues the results.
// Depends on cu_pkg; reads binomials from cu_binom_mem.
module cu_back #(
  parameter int N_MAX = cu_pkg::N_MAX_DEF,
  parameter int K_MAX = cu_pkg::K_MAX_DEF,
  localparam int AW = $clog2(N_MAX + 1),
  localparam int BW = $clog2(K_MAX + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cu_pkg::SET_W-1:0]    set_size,
  input  logic [cu_pkg::CHOOSE_W-1:0] choose_count,
  input  logic                        job_valid,
  input  cu_pkg::job_t                job,
  output logic                        job_pop,
  input  logic                        mem_ready,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_a,
  output logic [BW-1:0]               rd_b,
  input  logic [cu_pkg::RANK_W-1:0]   rd_data,
  output logic                        out_empty,
  input  logic                        out_pop,
  output cu_pkg::res_t                out_res
);

  typedef enum logic [2:0] {S_IDLE, S_CHK, S_STEP, S_FILL, S_ERR} state_t;

  state_t                    state_r, state_nxt;
  logic [cu_pkg::RANK_W-1:0] nr_r, nr_nxt;
  logic [cu_pkg::RANK_W:0]   sum_r, sum_nxt, s;
  logic [7:0]                z_r, z_nxt, n8;
  logic [4:0]                j_r, j_nxt;
  logic [3:0]                cnt_r, cnt_nxt;
  logic                      zero_r, zero_nxt;
  logic [cu_pkg::RANK_W-1:0] temp;
  logic                      push;
  cu_pkg::res_t              push_d;
  cu_pkg::res_t              fifo_r [2];
  logic                      head_r;
  logic [1:0]                fcnt_r;
  logic                      ofull, opop;

  assign n8 = {1'b0, set_size};
  assign temp = zero_r ? '0 : rd_data;
  assign s = sum_r + {1'b0, temp};
  assign ofull = (fcnt_r == 2'd2);
  assign out_empty = (fcnt_r == 2'd0);
  assign opop = out_pop && !out_empty;
  assign out_res = fifo_r[head_r];

  always_comb begin
    state_nxt = state_r;
    nr_nxt = nr_r;
    sum_nxt = sum_r;
    z_nxt = z_r;
    j_nxt = j_r;
    cnt_nxt = cnt_r;
    zero_nxt = zero_r;
    job_pop = 1'b0;
    rd_en = 1'b0;
    rd_a = '0;
    rd_b = '0;
    push = 1'b0;
    push_d = '0;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid && mem_ready) begin
          job_pop = 1'b1;
          nr_nxt = job.rank;
          if (job.err) begin
            state_nxt = S_ERR;
          end else begin
            rd_en = 1'b1;
            rd_a = AW'(set_size);
            rd_b = BW'(choose_count);
            zero_nxt = 1'b0;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (nr_r > rd_data) begin
          state_nxt = S_ERR;
        end else begin
          sum_nxt = '0;
          z_nxt = 8'd1;
          j_nxt = 5'd1;
          cnt_nxt = '0;
          rd_en = 1'b1;
          rd_a = AW'(n8 - 8'd1);
          rd_b = BW'(choose_count - 5'd1);
          zero_nxt = 1'b0;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if ((s < {1'b0, nr_r}) && (z_r < n8)) begin
          sum_nxt = s;
          z_nxt = z_r + 8'd1;
          rd_en = 1'b1;
          rd_a = AW'(n8 - z_r - 8'd1);
          rd_b = BW'(choose_count - j_r);
          zero_nxt = 1'b0;
        end else if (!ofull) begin
          push = 1'b1;
          push_d.element_value = z_r[cu_pkg::SET_W-1:0];
          push_d.position = cnt_r;
          push_d.last = (j_r == choose_count);
          push_d.error = 1'b0;
          if (j_r == choose_count) begin
            state_nxt = S_IDLE;
          end else if (s == {1'b0, nr_r}) begin
            j_nxt = j_r + 5'd1;
            cnt_nxt = cnt_r + 4'd1;
            state_nxt = S_FILL;
          end else begin
            z_nxt = z_r + 8'd1;
            j_nxt = j_r + 5'd1;
            cnt_nxt = cnt_r + 4'd1;
            rd_en = 1'b1;
            rd_a = AW'(n8 - z_r - 8'd1);
            rd_b = BW'(choose_count - j_r - 5'd1);
            zero_nxt = (z_r >= n8);
          end
        end
      end
      S_FILL: begin
        if (!ofull) begin
          push = 1'b1;
          push_d.element_value = cu_pkg::SET_W'(n8 - 8'(choose_count) + 8'(j_r));
          push_d.position = cnt_r;
          push_d.last = (j_r == choose_count);
          push_d.error = 1'b0;
          if (j_r == choose_count) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt = j_r + 5'd1;
            cnt_nxt = cnt_r + 4'd1;
          end
        end
      end
      S_ERR: begin
        if (!ofull) begin
          push = 1'b1;
          push_d.element_value = '0;
          push_d.position = '0;
          push_d.last = 1'b1;
          push_d.error = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= 1'b0;
      fcnt_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_r ^ opop;
      fcnt_r <= fcnt_r + {1'b0, push} - {1'b0, opop};
    end
    nr_r <= nr_nxt;
    sum_r <= sum_nxt;
    z_r <= z_nxt;
    j_r <= j_nxt;
    cnt_r <= cnt_nxt;
    zero_r <= zero_nxt;
    if (push) begin
      fifo_r[head_r ^ fcnt_r[0]] <= push_d;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !ofull) else $error("result pushed into a full queue");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_res.error) |-> (out_res.last && out_res.position == '0))
    else $error("error result not marked last");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (state_r == S_IDLE && mem_ready)) else $error("job taken while busy");
  a_chk_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> $past(rd_en)) else $error("check without table read");

endmodule

### test/combination_unrank_test.sv
// Self-checking testbench for the combination unranking block.
// Depends on cu_pkg and combination_unrank; predicts every result from its own Pascal table.
module combination_unrank_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cu_pkg::*;

  typedef struct {
    logic [SET_W-1:0] element_value;
    logic [POS_W-1:0] position;
    logic             last;
    logic             error;
  } subset_elem_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [RANK_W-1:0]     in_rank = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [SET_W-1:0]      out_element_value;
  logic [POS_W-1:0]      out_position;
  logic                  out_last;
  logic                  out_error;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SET_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  localparam int NMAX = N_MAX_DEF;
  localparam int KMAX = K_MAX_DEF;

  longint unsigned pascal[0:NMAX][0:KMAX];
  int unsigned     cur_n = SET_SIZE_RST;
  int unsigned     cur_k = CHOOSE_COUNT_RST;
  logic [RANK_W-1:0] rank_queue[$];
  subset_elem_t      subset_queue[$];
  bit  rank_taken = 1'b0;
  bit  calm = 1'b0;
  int  push_gap = 0;
  int  pop_gap = 0;
  int  failures = 0;

  combination_unrank uut (.*);

  always #4 clk = ~clk;

  function automatic longint unsigned choose(int a, int b);
    if (a < 0 || b < 0 || b > a || a > NMAX || b > KMAX) return 0;
    return pascal[a][b];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic predict_subset(logic [RANK_W-1:0] rank);
    int n, k, z, j, cnt;
    longint unsigned nr, total, temp;
    subset_elem_t e;
    n = cur_n;
    k = cur_k;
    nr = (rank == 0) ? 1 : rank;
    if (k == 0 || k > KMAX || n > NMAX || k > n || nr > choose(n, k)) begin
      e = '{element_value: '0, position: '0, last: 1'b1, error: 1'b1};
      subset_queue.push_back(e);
      return;
    end
    cnt = 0;
    total = 0;
    z = 1;
    for (j = 1; j <= k; j++) begin
      temp = choose(n - z, k - j);
      while (total + temp < nr && z < n) begin
        total += temp;
        z++;
        temp = choose(n - z, k - j);
      end
      e = '{element_value: z[SET_W-1:0], position: cnt[POS_W-1:0],
            last: (j == k), error: 1'b0};
      subset_queue.push_back(e);
      cnt++;
      if (total + temp == nr) begin
        for (j = j + 1; j <= k; j++) begin
          e = '{element_value: SET_W'(n - (k - j)), position: cnt[POS_W-1:0],
                last: (j == k), error: 1'b0};
          subset_queue.push_back(e);
          cnt++;
        end
        break;
      end
      z++;
    end
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_push || rank_taken) begin
        if (push_gap > 0) begin
          in_push <= 1'b0;
          push_gap--;
        end else if (rank_queue.size() > 0) begin
          in_rank <= rank_queue.pop_front();
          in_push <= 1'b1;
          push_gap = pick_gap();
        end else begin
          in_push <= 1'b0;
        end
      end
      if (pop_gap > 0) begin
        out_pop <= 1'b0;
        pop_gap--;
      end else begin
        out_pop <= 1'b1;
        pop_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    subset_elem_t want;
    rank_taken = in_push && !in_full;
    if (rst_n) begin
      if (cfg_write_en) begin
        if (cfg_index == CFG_SET_SIZE) cur_n = cfg_data & 7'h7F;
        else cur_k = cfg_data & 7'h1F;
      end
      if (rank_taken) predict_subset(in_rank);
      if (out_pop && !out_empty) begin
        if (subset_queue.size() == 0) begin
          $error("unexpected transaction: value %0d position %0d", out_element_value,
                 out_position);
          failures++;
        end else begin
          want = subset_queue.pop_front();
          if (out_element_value !== want.element_value) begin
            $error("element_value: expected %0d, got %0d", want.element_value,
                   out_element_value);
            failures++;
          end
          if (out_position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_position);
            failures++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            failures++;
          end
          if (out_error !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, out_error);
            failures++;
          end
        end
      end
    end
  end

  task automatic wait_idle();
    while (rank_queue.size() > 0 || in_push || subset_queue.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    int ns[$] = '{49, 1, 64, 64, 5, 3, 100, 10, 20, 127, 16, 64, 7, 0, 0, 0};
    int ks[$] = '{6, 1, 16, 1, 5, 4, 3, 0, 17, 31, 8, 2, 3, 0, 0, 0};
    longint unsigned c;
    logic [RANK_W-1:0] r;
    int p, i, roll;
    for (int a = 0; a <= NMAX; a++)
      for (int b = 0; b <= KMAX; b++)
        pascal[a][b] = (b == 0) ? 1 : (a == 0) ? 0 : pascal[a - 1][b] + pascal[a - 1][b - 1];
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    for (p = 0; p < ns.size(); p++) begin
      if (p > 0) begin
        wait_idle();
        if (ns[p] == 0) begin
          ns[p] = $urandom_range(64, 1);
          ks[p] = $urandom_range(ns[p] < 16 ? ns[p] : 16, 1);
        end
        write_reg(CFG_SET_SIZE, ns[p]);
        write_reg(CFG_CHOOSE_COUNT, ks[p]);
        @(negedge clk);
      end
      calm = (p % 3 == 2);
      c = (ks[p] == 0 || ks[p] > KMAX || ns[p] > NMAX) ? 0 : choose(ns[p], ks[p]);
      if (p < 5) begin
        rank_queue.push_back('0);
        rank_queue.push_back(64'd1);
        rank_queue.push_back(c);
        rank_queue.push_back(c + 1);
        if (p < 2) rank_queue.push_back('1);
      end
      for (i = 0; i < 28; i++) begin
        r = {$urandom, $urandom};
        roll = $urandom_range(99);
        if (roll < 5) r = '0;
        else if (roll < 88 && c > 0) r = (r % c) + 1;
        rank_queue.push_back(r);
      end
    end
    wait_idle();
    if (failures == 0 && subset_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end
endmodule
